// ===== src/track_table_segment_vote_counter_top_defines.svh =====
// Assertion macros for the track table segment vote counter.
`ifndef TRACK_TABLE_SEGMENT_VOTE_COUNTER_TOP_DEFINES_SVH
`define TRACK_TABLE_SEGMENT_VOTE_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TTSVC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define TTSVC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/ttsvc_pkg.sv =====
// Shared types, constants and helpers of the track table segment vote counter.
`timescale 1ns / 1ps
package ttsvc_pkg;

  localparam int MAX_TRACKS = 32;
  localparam int MAX_SEGS   = 16;
  localparam int TRK_AW     = $clog2(MAX_TRACKS);
  localparam int TCNT_W     = $clog2(MAX_TRACKS + 1);
  localparam int SEG_AW     = $clog2(MAX_SEGS);
  localparam int SCNT_W     = $clog2(MAX_SEGS + 1);
  localparam int SEG_DEPTH  = MAX_TRACKS * MAX_SEGS;

  // request codes
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_COUNT = 2'd3
  } req_e;

  // class letters and their colours (first channel in the low byte)
  localparam logic [7:0]  LET_P = 8'h70;
  localparam logic [7:0]  LET_R = 8'h72;
  localparam logic [7:0]  LET_C = 8'h63;
  localparam logic [7:0]  LET_B = 8'h62;
  localparam logic [7:0]  LET_T = 8'h74;
  localparam logic [23:0] COL_P     = 24'h0000FF;
  localparam logic [23:0] COL_R     = 24'h0080FF;
  localparam logic [23:0] COL_C     = 24'hFF0000;
  localparam logic [23:0] COL_B     = 24'h8000FF;
  localparam logic [23:0] COL_T     = 24'h00FF00;
  localparam logic [23:0] COL_OTHER = 24'hFFFFFF;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] local_id;
    logic [7:0]  class_letter;
    logic [15:0] score_in;
    logic [11:0] box_x;
    logic [11:0] box_y;
    logic [11:0] box_w;
    logic [11:0] box_h;
    logic [15:0] segment_id;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [15:0] global_id;
    logic [7:0]  class_out;
    logic [23:0] color_out;
    logic [15:0] score_out;
    logic [11:0] out_box_x;
    logic [11:0] out_box_y;
    logic [11:0] out_box_w;
    logic [11:0] out_box_h;
    logic [15:0] seg_out;
    logic [15:0] seg_points;
    logic        last;
  } out_t;

  // one stored track
  typedef struct packed {
    logic [15:0] local_id;
    logic [15:0] global_id;
    logic [7:0]  class_letter;
    logic [23:0] color;
    logic [15:0] score;
    logic [11:0] box_x;
    logic [11:0] box_y;
    logic [11:0] box_w;
    logic [11:0] box_h;
  } trk_t;

  // one segment entry
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] count;
  } seg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_TRD,
    ST_TCHK,
    ST_QSTART,
    ST_QRD,
    ST_QEMIT,
    ST_CRD,
    ST_CCHK,
    ST_CAPP
  } state_e;

  function automatic logic [23:0] color_of(input logic [7:0] letter);
    logic [23:0] c;
    case (letter)
      LET_P:   c = COL_P;
      LET_R:   c = COL_R;
      LET_C:   c = COL_C;
      LET_B:   c = COL_B;
      LET_T:   c = COL_T;
      default: c = COL_OTHER;
    endcase
    return c;
  endfunction

endpackage

// ===== src/ttsvc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module ttsvc_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held when not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ttsvc_seq.sv =====
// Request sequencer with the track, segment-fill and segment memories.
`timescale 1ns / 1ps
module ttsvc_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  ttsvc_pkg::in_t   in_data_i,
  output logic             in_stall_o,
  input  logic             slot_free_i,
  output logic             emit_o,
  output ttsvc_pkg::out_t  res_o
);

  ttsvc_pkg::state_e state_q, state_d;
  ttsvc_pkg::in_t    item_q, item_d;
  ttsvc_pkg::trk_t   trk_q, trk_d;
  logic [ttsvc_pkg::TCNT_W-1:0] cnt_q, cnt_d;
  logic [ttsvc_pkg::TCNT_W-1:0] t_q, t_d;
  logic [ttsvc_pkg::SCNT_W-1:0] s_q, s_d;
  logic [ttsvc_pkg::SCNT_W-1:0] n_q, n_d;
  logic [15:0] ngid_q, ngid_d;
  logic [15:0] pts_q, pts_d;
  logic        any_q, any_d;
  logic        drop_q, drop_d;
  logic        first_q, first_d;

  // memory ports
  logic                            info_we, info_re;
  ttsvc_pkg::trk_t                 info_wdata, info_rd;
  logic [$bits(ttsvc_pkg::trk_t)-1:0] info_rdata;
  logic                            used_we, used_re;
  logic [ttsvc_pkg::SCNT_W-1:0]    used_wdata, used_rdata;
  logic [ttsvc_pkg::TRK_AW-1:0]    trk_waddr;
  logic                            seg_we, seg_re;
  logic [ttsvc_pkg::TRK_AW+ttsvc_pkg::SEG_AW-1:0] seg_waddr, seg_raddr;
  ttsvc_pkg::seg_t                 seg_wdata, seg_rd;
  logic [$bits(ttsvc_pkg::seg_t)-1:0] seg_rdata;

  // result assembly
  ttsvc_pkg::trk_t res_trk, new_trk;
  logic            res_found, res_last;
  logic [15:0]     res_seg, res_pts;

  // finishing one matching track during a count
  logic        fin;
  logic [15:0] fin_pts, inc_cnt;

  ttsvc_ram #(.Width($bits(ttsvc_pkg::trk_t)), .Depth(ttsvc_pkg::MAX_TRACKS)) u_info (
    .clk_i   (clk_i),
    .we_i    (info_we),
    .waddr_i (trk_waddr),
    .wdata_i (info_wdata),
    .re_i    (info_re),
    .raddr_i (t_q[ttsvc_pkg::TRK_AW-1:0]),
    .rdata_o (info_rdata)
  );

  ttsvc_ram #(.Width(ttsvc_pkg::SCNT_W), .Depth(ttsvc_pkg::MAX_TRACKS)) u_used (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (trk_waddr),
    .wdata_i (used_wdata),
    .re_i    (used_re),
    .raddr_i (t_q[ttsvc_pkg::TRK_AW-1:0]),
    .rdata_o (used_rdata)
  );

  ttsvc_ram #(.Width($bits(ttsvc_pkg::seg_t)), .Depth(ttsvc_pkg::SEG_DEPTH)) u_seg (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (seg_waddr),
    .wdata_i (seg_wdata),
    .re_i    (seg_re),
    .raddr_i (seg_raddr),
    .rdata_o (seg_rdata)
  );

  assign info_rd   = ttsvc_pkg::trk_t'(info_rdata);
  assign seg_rd    = ttsvc_pkg::seg_t'(seg_rdata);
  assign seg_raddr = {t_q[ttsvc_pkg::TRK_AW-1:0], s_q[ttsvc_pkg::SEG_AW-1:0]};
  assign inc_cnt   = (seg_rd.count == ttsvc_pkg::CNT_MAX) ? seg_rd.count
                                                          : seg_rd.count + 16'd1;

  // track built from an add request
  always_comb begin
    new_trk.local_id     = item_q.local_id;
    new_trk.global_id    = ngid_q + 16'd1;
    new_trk.class_letter = item_q.class_letter;
    new_trk.color        = ttsvc_pkg::color_of(item_q.class_letter);
    new_trk.score        = item_q.score_in;
    new_trk.box_x        = item_q.box_x;
    new_trk.box_y        = item_q.box_y;
    new_trk.box_w        = item_q.box_w;
    new_trk.box_h        = item_q.box_h;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttsvc_pkg::ST_IDLE;
      cnt_q   <= '0;
      ngid_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ngid_q  <= ngid_d;
    end
  end

  // working registers of the current transaction
  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    trk_q   <= trk_d;
    t_q     <= t_d;
    s_q     <= s_d;
    n_q     <= n_d;
    pts_q   <= pts_d;
    any_q   <= any_d;
    drop_q  <= drop_d;
    first_q <= first_d;
  end

  // next state, memory control and results
  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    trk_d      = trk_q;
    cnt_d      = cnt_q;
    ngid_d     = ngid_q;
    t_d        = t_q;
    s_d        = s_q;
    n_d        = n_q;
    pts_d      = pts_q;
    any_d      = any_q;
    drop_d     = drop_q;
    first_d    = first_q;
    info_we    = 1'b0;
    info_re    = 1'b0;
    info_wdata = new_trk;
    used_we    = 1'b0;
    used_re    = 1'b0;
    used_wdata = '0;
    trk_waddr  = t_q[ttsvc_pkg::TRK_AW-1:0];
    seg_we     = 1'b0;
    seg_re     = 1'b0;
    seg_waddr  = seg_raddr;
    seg_wdata  = seg_rd;
    emit_o     = 1'b0;
    res_trk    = '0;
    res_found  = 1'b0;
    res_last   = 1'b1;
    res_seg    = '0;
    res_pts    = '0;
    fin        = 1'b0;
    fin_pts    = '0;
    in_stall_o = (state_q != ttsvc_pkg::ST_IDLE);

    case (state_q)
      ttsvc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = ttsvc_pkg::ST_DISP;
        end
      end

      ttsvc_pkg::ST_DISP: begin
        if (item_q.req_type == ttsvc_pkg::REQ_CLEAR) begin
          res_found = 1'b1;
          if (slot_free_i) begin
            emit_o  = 1'b1;
            cnt_d   = '0;
            state_d = ttsvc_pkg::ST_IDLE;
          end
        end else if (item_q.req_type == ttsvc_pkg::REQ_ADD) begin
          if (cnt_q < ttsvc_pkg::TCNT_W'(ttsvc_pkg::MAX_TRACKS)) begin
            res_found = 1'b1;
            res_trk   = new_trk;
            trk_waddr = cnt_q[ttsvc_pkg::TRK_AW-1:0];
            if (slot_free_i) begin
              emit_o  = 1'b1;
              info_we = 1'b1;
              used_we = 1'b1;
              ngid_d  = new_trk.global_id;
              cnt_d   = cnt_q + ttsvc_pkg::TCNT_W'(1);
              state_d = ttsvc_pkg::ST_IDLE;
            end
          end else if (slot_free_i) begin
            emit_o  = 1'b1;
            state_d = ttsvc_pkg::ST_IDLE;
          end
        end else begin
          // query or count: scan from the first track
          trk_d   = '0;
          t_d     = '0;
          pts_d   = '0;
          any_d   = 1'b0;
          drop_d  = 1'b0;
          first_d = 1'b0;
          state_d = ttsvc_pkg::ST_TRD;
        end
      end

      ttsvc_pkg::ST_TRD: begin
        info_re = 1'b1;
        used_re = 1'b1;
        state_d = ttsvc_pkg::ST_TCHK;
      end

      ttsvc_pkg::ST_TCHK: begin
        if (t_q >= cnt_q) begin
          // end of table
          if (item_q.req_type == ttsvc_pkg::REQ_COUNT) begin
            res_found = any_q & ~drop_q;
            res_trk   = trk_q;
            res_seg   = item_q.segment_id;
            res_pts   = pts_q;
          end
          if (slot_free_i) begin
            emit_o  = 1'b1;
            state_d = ttsvc_pkg::ST_IDLE;
          end
        end else if (info_rd.local_id == item_q.local_id) begin
          n_d = used_rdata;
          s_d = '0;
          if (item_q.req_type == ttsvc_pkg::REQ_QUERY) begin
            trk_d   = info_rd;
            state_d = ttsvc_pkg::ST_QSTART;
          end else begin
            if (!any_q) begin
              trk_d = info_rd;
            end
            first_d = ~any_q;
            any_d   = 1'b1;
            state_d = (used_rdata == '0) ? ttsvc_pkg::ST_CAPP : ttsvc_pkg::ST_CRD;
          end
        end else begin
          t_d     = t_q + ttsvc_pkg::TCNT_W'(1);
          state_d = ttsvc_pkg::ST_TRD;
        end
      end

      ttsvc_pkg::ST_QSTART: begin
        if (n_q == '0) begin
          res_found = 1'b1;
          res_trk   = trk_q;
          if (slot_free_i) begin
            emit_o  = 1'b1;
            state_d = ttsvc_pkg::ST_IDLE;
          end
        end else begin
          state_d = ttsvc_pkg::ST_QRD;
        end
      end

      ttsvc_pkg::ST_QRD: begin
        seg_re  = 1'b1;
        state_d = ttsvc_pkg::ST_QEMIT;
      end

      ttsvc_pkg::ST_QEMIT: begin
        res_found = 1'b1;
        res_trk   = trk_q;
        res_seg   = seg_rd.id;
        res_pts   = seg_rd.count;
        res_last  = ((s_q + ttsvc_pkg::SCNT_W'(1)) == n_q);
        if (slot_free_i) begin
          emit_o = 1'b1;
          if (res_last) begin
            state_d = ttsvc_pkg::ST_IDLE;
          end else begin
            s_d     = s_q + ttsvc_pkg::SCNT_W'(1);
            state_d = ttsvc_pkg::ST_QRD;
          end
        end
      end

      ttsvc_pkg::ST_CRD: begin
        seg_re  = 1'b1;
        state_d = ttsvc_pkg::ST_CCHK;
      end

      ttsvc_pkg::ST_CCHK: begin
        if (seg_rd.id == item_q.segment_id) begin
          // known segment: saturating increment
          seg_we          = 1'b1;
          seg_wdata.id    = seg_rd.id;
          seg_wdata.count = inc_cnt;
          fin             = 1'b1;
          fin_pts         = inc_cnt;
        end else if ((s_q + ttsvc_pkg::SCNT_W'(1)) == n_q) begin
          state_d = ttsvc_pkg::ST_CAPP;
        end else begin
          s_d     = s_q + ttsvc_pkg::SCNT_W'(1);
          state_d = ttsvc_pkg::ST_CRD;
        end
      end

      ttsvc_pkg::ST_CAPP: begin
        fin = 1'b1;
        if (n_q < ttsvc_pkg::SCNT_W'(ttsvc_pkg::MAX_SEGS)) begin
          // new segment appended at count one
          seg_we          = 1'b1;
          seg_waddr       = {t_q[ttsvc_pkg::TRK_AW-1:0], n_q[ttsvc_pkg::SEG_AW-1:0]};
          seg_wdata.id    = item_q.segment_id;
          seg_wdata.count = 16'd1;
          used_we         = 1'b1;
          used_wdata      = n_q + ttsvc_pkg::SCNT_W'(1);
          fin_pts         = 16'd1;
        end else begin
          drop_d = 1'b1;
        end
      end

      default: begin
        state_d = ttsvc_pkg::ST_IDLE;
      end
    endcase

    // a matching track is done: note its count if it is the first match, move to the next track
    if (fin) begin
      if (first_q) begin
        pts_d = fin_pts;
      end
      t_d     = t_q + ttsvc_pkg::TCNT_W'(1);
      state_d = ttsvc_pkg::ST_TRD;
    end
  end

  // result fields
  always_comb begin
    res_o.found      = res_found;
    res_o.global_id  = res_trk.global_id;
    res_o.class_out  = res_trk.class_letter;
    res_o.color_out  = res_trk.color;
    res_o.score_out  = res_trk.score;
    res_o.out_box_x  = res_trk.box_x;
    res_o.out_box_y  = res_trk.box_y;
    res_o.out_box_w  = res_trk.box_w;
    res_o.out_box_h  = res_trk.box_h;
    res_o.seg_out    = res_seg;
    res_o.seg_points = res_pts;
    res_o.last       = res_last;
  end

endmodule

// ===== src/track_table_segment_vote_counter_top.sv =====
// Top level of the track table segment vote counter: sequencer and result register.
`timescale 1ns / 1ps
// The block works on one request at a time and holds in_stall_o high from the
// cycle after acceptance until the request's last result has been loaded into
// the output register. Clear and add are answered from the dispatch state.
// Query and count walk the track memory with one read and one compare step per
// stored track; a query hit then passes a start step and a read and an emit
// step per stored segment of that track, and a count does a read and a compare
// step per segment searched for each matching track, plus an append step when it
// appends or finds the list full (an increment is written in the compare step).
// The walk is serial, as the track and segment memories each have one read port.
// Results wait in a one-deep output register; a stalled output only holds up the next result.
`include "track_table_segment_vote_counter_top_defines.svh"
module track_table_segment_vote_counter_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  ttsvc_pkg::in_t  in_data_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output ttsvc_pkg::out_t out_data_o,
  input  logic            out_stall_i
);

  logic            emit;
  logic            slot_free;
  logic            out_valid_q, out_valid_d;
  ttsvc_pkg::out_t res;
  ttsvc_pkg::out_t out_data_q;

  assign slot_free = ~out_valid_q | ~out_stall_i;

  ttsvc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .slot_free_i (slot_free),
    .emit_o      (emit),
    .res_o       (res)
  );

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  `TTSVC_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `TTSVC_ASSERT_IMP(a_no_overwrite, emit, !out_valid_q || !out_stall_i)
  `TTSVC_ASSERT_IMP(a_idle_no_emit, !in_stall_o, !emit)

endmodule

// ===== tb/track_table_segment_vote_counter_top_test.sv =====
// Self-checking testbench of the track table segment vote counter.
`timescale 1ns / 1ps
module track_table_segment_vote_counter_top_test;

  localparam int MAX_CYCLES = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  ttsvc_pkg::in_t  in_data_i = '0;
  logic in_stall_o;
  logic out_valid_o;
  ttsvc_pkg::out_t out_data_o;
  logic out_stall_i = 1'b0;

  track_table_segment_vote_counter_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_data_i(in_data_i), .in_stall_o(in_stall_o),
    .out_valid_o(out_valid_o), .out_data_o(out_data_o), .out_stall_i(out_stall_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predicted table contents
  ttsvc_pkg::trk_t tracks[ttsvc_pkg::MAX_TRACKS];
  ttsvc_pkg::seg_t segs[ttsvc_pkg::MAX_TRACKS][ttsvc_pkg::MAX_SEGS];
  int unsigned     seg_fill[ttsvc_pkg::MAX_TRACKS];
  int unsigned     n_tracks;
  logic [15:0]     gid_ctr;

  ttsvc_pkg::in_t  pending_q[$];
  ttsvc_pkg::out_t expected_q[$];
  int   errors = 0;
  int   cycles = 0;
  bit   hold_sender = 1'b0;
  bit   in_taken = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   stall_mode = 0;

  function automatic void add_pending(ttsvc_pkg::in_t it);
    pending_q.insert(pending_q.size(), it);
  endfunction

  function automatic void add_expected(ttsvc_pkg::out_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic logic [23:0] class_colour(logic [7:0] l);
    case (l)
      ttsvc_pkg::LET_P: return ttsvc_pkg::COL_P;
      ttsvc_pkg::LET_R: return ttsvc_pkg::COL_R;
      ttsvc_pkg::LET_C: return ttsvc_pkg::COL_C;
      ttsvc_pkg::LET_B: return ttsvc_pkg::COL_B;
      ttsvc_pkg::LET_T: return ttsvc_pkg::COL_T;
      default:          return ttsvc_pkg::COL_OTHER;
    endcase
  endfunction

  function automatic ttsvc_pkg::out_t track_fields(int unsigned t);
    ttsvc_pkg::out_t r;
    r = '0;
    r.found = 1'b1;
    r.global_id = tracks[t].global_id;
    r.class_out = tracks[t].class_letter;
    r.color_out = tracks[t].color;
    r.score_out = tracks[t].score;
    r.out_box_x = tracks[t].box_x;
    r.out_box_y = tracks[t].box_y;
    r.out_box_w = tracks[t].box_w;
    r.out_box_h = tracks[t].box_h;
    return r;
  endfunction

  // apply one request to the predicted table and queue its results
  task automatic predict_request(ttsvc_pkg::in_t it);
    ttsvc_pkg::out_t r;
    bit   any, dropped, hit, first;
    logic [15:0] pts, first_pts;
    int unsigned n;
    r = '0;
    case (ttsvc_pkg::req_e'(it.req_type))
      ttsvc_pkg::REQ_CLEAR: begin
        n_tracks = 0;
        r.found = 1'b1;
        r.last = 1'b1;
        add_expected(r);
      end
      ttsvc_pkg::REQ_ADD: begin
        if (n_tracks < ttsvc_pkg::MAX_TRACKS) begin
          gid_ctr = gid_ctr + 16'd1;
          tracks[n_tracks] = '{it.local_id, gid_ctr, it.class_letter,
                               class_colour(it.class_letter), it.score_in,
                               it.box_x, it.box_y, it.box_w, it.box_h};
          seg_fill[n_tracks] = 0;
          r = track_fields(n_tracks);
          n_tracks++;
        end
        r.last = 1'b1;
        add_expected(r);
      end
      ttsvc_pkg::REQ_QUERY: begin
        hit = 1'b0;
        for (int unsigned t = 0; t < n_tracks && !hit; t++) begin
          if (tracks[t].local_id == it.local_id) begin
            hit = 1'b1;
            if (seg_fill[t] == 0) begin
              r = track_fields(t);
              r.last = 1'b1;
              add_expected(r);
            end else begin
              for (int unsigned s = 0; s < seg_fill[t]; s++) begin
                r = track_fields(t);
                r.seg_out = segs[t][s].id;
                r.seg_points = segs[t][s].count;
                r.last = (s + 1 == seg_fill[t]);
                add_expected(r);
              end
            end
          end
        end
        if (!hit) begin
          r.last = 1'b1;
          add_expected(r);
        end
      end
      default: begin
        any = 1'b0; dropped = 1'b0; first = 1'b1; first_pts = '0;
        for (int unsigned t = 0; t < n_tracks; t++) begin
          if (tracks[t].local_id != it.local_id) continue;
          n = seg_fill[t];
          pts = '0;
          hit = 1'b0;
          for (int unsigned s = 0; s < n && !hit; s++) begin
            if (segs[t][s].id == it.segment_id) begin
              if (segs[t][s].count != ttsvc_pkg::CNT_MAX) segs[t][s].count++;
              pts = segs[t][s].count;
              hit = 1'b1;
            end
          end
          if (!hit) begin
            if (n < ttsvc_pkg::MAX_SEGS) begin
              segs[t][n] = '{it.segment_id, 16'd1};
              seg_fill[t] = n + 1;
              pts = 16'd1;
            end else begin
              dropped = 1'b1;
            end
          end
          any = 1'b1;
          if (first) begin
            r = track_fields(t);
            first_pts = pts;
            first = 1'b0;
          end
        end
        r.found = any && !dropped;
        r.seg_out = it.segment_id;
        r.seg_points = first_pts;
        r.last = 1'b1;
        add_expected(r);
      end
    endcase
  endtask

  function automatic ttsvc_pkg::in_t make_req(ttsvc_pkg::req_e op, logic [15:0] lid,
                                              logic [15:0] sid);
    ttsvc_pkg::in_t it;
    it.req_type = op;
    it.local_id = lid;
    it.class_letter = 8'($urandom);
    it.score_in = 16'($urandom);
    it.box_x = 12'($urandom);
    it.box_y = 12'($urandom);
    it.box_w = 12'($urandom);
    it.box_h = 12'($urandom);
    it.segment_id = sid;
    return it;
  endfunction

  // driver: bursts of transactions with random gaps, changes at falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0 && !hold_sender) begin
          in_data_i <= pending_q.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      // receiver stall pattern, mode changes now and then
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 1) == 0);
        default: out_stall_i <= (cycles % 7) < 4;
      endcase
    end
  end

  // monitor: predicts on input acceptance, checks on output acceptance
  always @(posedge clk_i) begin
    ttsvc_pkg::out_t e;
    cycles <= cycles + 1;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_request(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction %p", out_data_o);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_data_o.found !== e.found) begin
            $error("found exp %0h got %0h", e.found, out_data_o.found); errors++;
          end
          if (out_data_o.global_id !== e.global_id) begin
            $error("global_id exp %0h got %0h", e.global_id, out_data_o.global_id);
            errors++;
          end
          if (out_data_o.class_out !== e.class_out) begin
            $error("class_out exp %0h got %0h", e.class_out, out_data_o.class_out);
            errors++;
          end
          if (out_data_o.color_out !== e.color_out) begin
            $error("color_out exp %0h got %0h", e.color_out, out_data_o.color_out);
            errors++;
          end
          if (out_data_o.score_out !== e.score_out) begin
            $error("score_out exp %0h got %0h", e.score_out, out_data_o.score_out);
            errors++;
          end
          if (out_data_o.out_box_x !== e.out_box_x) begin
            $error("out_box_x exp %0h got %0h", e.out_box_x, out_data_o.out_box_x);
            errors++;
          end
          if (out_data_o.out_box_y !== e.out_box_y) begin
            $error("out_box_y exp %0h got %0h", e.out_box_y, out_data_o.out_box_y);
            errors++;
          end
          if (out_data_o.out_box_w !== e.out_box_w) begin
            $error("out_box_w exp %0h got %0h", e.out_box_w, out_data_o.out_box_w);
            errors++;
          end
          if (out_data_o.out_box_h !== e.out_box_h) begin
            $error("out_box_h exp %0h got %0h", e.out_box_h, out_data_o.out_box_h);
            errors++;
          end
          if (out_data_o.seg_out !== e.seg_out) begin
            $error("seg_out exp %0h got %0h", e.seg_out, out_data_o.seg_out);
            errors++;
          end
          if (out_data_o.seg_points !== e.seg_points) begin
            $error("seg_points exp %0h got %0h", e.seg_points, out_data_o.seg_points);
            errors++;
          end
          if (out_data_o.last !== e.last) begin
            $error("last exp %0h got %0h", e.last, out_data_o.last); errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycles > MAX_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus
  initial begin
    ttsvc_pkg::in_t it;
    logic [15:0] lid;
    int op;
    n_tracks = 0;
    gid_ctr = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: empty table, field extremes, every class letter
    add_pending(make_req(ttsvc_pkg::REQ_QUERY, 16'h0000, 16'h0000));
    add_pending(make_req(ttsvc_pkg::REQ_COUNT, 16'h0000, 16'hFFFF));
    it = make_req(ttsvc_pkg::REQ_ADD, 16'hFFFF, 16'h0);
    it.class_letter = 8'hFF; it.score_in = 16'hFFFF;
    it.box_x = '1; it.box_y = '1; it.box_w = '1; it.box_h = '1;
    add_pending(it);
    it = make_req(ttsvc_pkg::REQ_ADD, 16'h0000, 16'h0);
    it.class_letter = 8'h00; it.score_in = '0;
    it.box_x = '0; it.box_y = '0; it.box_w = '0; it.box_h = '0;
    add_pending(it);
    it = make_req(ttsvc_pkg::REQ_ADD, 16'd5, 16'd0);
    it.class_letter = ttsvc_pkg::LET_P; add_pending(it);
    it = make_req(ttsvc_pkg::REQ_ADD, 16'd5, 16'd0);
    it.class_letter = ttsvc_pkg::LET_R; add_pending(it);
    it = make_req(ttsvc_pkg::REQ_ADD, 16'd6, 16'd0);
    it.class_letter = ttsvc_pkg::LET_C; add_pending(it);
    it = make_req(ttsvc_pkg::REQ_ADD, 16'd7, 16'd0);
    it.class_letter = ttsvc_pkg::LET_B; add_pending(it);
    it = make_req(ttsvc_pkg::REQ_ADD, 16'd8, 16'd0);
    it.class_letter = ttsvc_pkg::LET_T; add_pending(it);
    add_pending(make_req(ttsvc_pkg::REQ_QUERY, 16'd6, 16'd0));        // hit, no segments
    add_pending(make_req(ttsvc_pkg::REQ_COUNT, 16'd5, 16'hFFFF));     // two tracks, new segment
    add_pending(make_req(ttsvc_pkg::REQ_COUNT, 16'd5, 16'hFFFF));     // existing segment
    add_pending(make_req(ttsvc_pkg::REQ_COUNT, 16'd5, 16'h0000));
    add_pending(make_req(ttsvc_pkg::REQ_QUERY, 16'd5, 16'd0));
    add_pending(make_req(ttsvc_pkg::REQ_QUERY, 16'hFFFF, 16'd0));
    add_pending(make_req(ttsvc_pkg::REQ_QUERY, 16'h1234, 16'd0));     // miss
    add_pending(make_req(ttsvc_pkg::REQ_CLEAR, 16'hFFFF, 16'hFFFF));
    add_pending(make_req(ttsvc_pkg::REQ_QUERY, 16'd5, 16'd0));        // miss after clear

    // fill the table past full, then overfill the segment lists of local id 1
    for (int i = 0; i < ttsvc_pkg::MAX_TRACKS + 2; i++)
      add_pending(make_req(ttsvc_pkg::REQ_ADD, 16'(i % 3), 16'd0));
    for (int i = 0; i < ttsvc_pkg::MAX_SEGS + 2; i++)
      add_pending(make_req(ttsvc_pkg::REQ_COUNT, 16'd1, 16'(i)));
    add_pending(make_req(ttsvc_pkg::REQ_QUERY, 16'd1, 16'd0));

    // pause the sender until the block has drained
    wait (pending_q.size() == 0);
    hold_sender = 1'b1;
    wait (!in_valid_i && expected_q.size() == 0);
    hold_sender = 1'b0;

    // random: few local ids and segment ids so hits, repeats and full lists occur
    for (int i = 0; i < 180; i++) begin
      op = $urandom_range(0, 99);
      lid = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
      if (op < 3)       it = make_req(ttsvc_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom));
      else if (op < 33) it = make_req(ttsvc_pkg::REQ_ADD, lid, 16'($urandom));
      else if (op < 55) it = make_req(ttsvc_pkg::REQ_QUERY, lid, 16'($urandom));
      else it = make_req(ttsvc_pkg::REQ_COUNT, lid,
                         ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 19)));
      add_pending(it);
    end
    wait (pending_q.size() == 0 && !in_valid_i);
    wait (expected_q.size() == 0);
    repeat (1200) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
